// ----- rtl/dltq_pkg.sv -----
package dltq_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = $clog2(ENTRIES + 1);
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int HANDLE_W  = 5;
    localparam int DELTA_W   = 32;
    localparam int ARG_W     = 32;
    localparam int CMD_W     = 2;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);

    localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

endpackage

// ----- rtl/dltq_ram.sv -----
module dltq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/delta_list_timer_queue.sv -----
// Delta-sorted timer queue over a fixed pool of 16 entries.
// Input channel (i_valid/o_ready) carries one command word: set, modify,
// delete or no-op, with handle, delay, argument and the current tick.
// Output channel (o_valid/i_ready) returns one result word per command:
// status, resulting handle, and the current head entry with its delta.
// The block works on one command at a time. An unlink walk checks one entry
// per cycle; an insert walk reads each entry's delta, then compares and
// subtracts in the one shared adder. A modify runs an unlink walk, a delta
// fold and a full insert walk.
// o_ready is high only when no command is in work and the result register
// is empty or being taken. A stalled receiver holds the result register;
// no new command is taken until it drains. The user is to write i_cfg_wdata
// into the time base through i_cfg_we only while idle; the block does not enforce it.
// Reset (synchronous, active low) empties the timer list and chains all
// entries into the free list; it clears at once, no clearing pass.
module delta_list_timer_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [31:0]                      i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [dltq_pkg::CMD_W-1:0]       i_command,
    input  logic [dltq_pkg::HANDLE_W-1:0]    i_handle,
    input  logic [dltq_pkg::DELTA_W-1:0]     i_delay_ms,
    input  logic [dltq_pkg::ARG_W-1:0]       i_timer_argument,
    input  logic [dltq_pkg::DELTA_W-1:0]     i_now_ms,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_status,
    output logic [dltq_pkg::HANDLE_W-1:0]    o_handle_out,
    output logic [dltq_pkg::HANDLE_W-1:0]    o_head_handle,
    output logic [dltq_pkg::DELTA_W-1:0]     o_head_delta_ms
);
    import dltq_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_DISP   = 11'b00000000010,
        S_UWALK  = 11'b00000000100,
        S_URD    = 11'b00000001000,
        S_USUCC  = 11'b00000010000,
        S_UFOLD  = 11'b00000100000,
        S_IRD    = 11'b00001000000,
        S_ICHK   = 11'b00010000000,
        S_IDONE  = 11'b00100000000,
        S_HRD    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // links are flip-flops (valid reset needed); deltas and args in RAM
    logic [IDX_W-1:0] r_link [ENTRIES];
    logic [IDX_W-1:0] r_active_head, r_free_head;
    logic [31:0]      r_time_base;

    logic [CMD_W-1:0]    r_cmd;
    logic [HANDLE_W-1:0] r_handle;
    logic [IDX_W-1:0]    r_ent;
    logic [31:0]         r_t;
    logic [ARG_W-1:0]    r_arg;
    logic [IDX_W-1:0]    r_prev, r_cur;
    logic                r_free_walk;   // unlink walks the free list
    logic                r_status;
    logic [HANDLE_W-1:0] r_hout;
    logic                r_ovalid;
    logic [HANDLE_W-1:0] r_oh;
    logic [31:0]         r_od;
    logic [ADDR_W:0]     r_cnt;
    logic [31:0]         r_saved;       // delta of entry being unlinked

    // delta RAM port
    logic              d_we;
    logic [ADDR_W-1:0] d_waddr, d_raddr;
    logic [31:0]       d_wdata, d_rdata;
    logic              a_we;
    logic [ARG_W-1:0]  a_rdata;

    dltq_ram #(.WIDTH(DELTA_W), .DEPTH(ENTRIES)) u_delta (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );
    dltq_ram #(.WIDTH(ARG_W), .DEPTH(ENTRIES)) u_arg (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(r_ent[ADDR_W-1:0]), .i_wdata(r_arg),
        .i_raddr(r_ent[ADDR_W-1:0]), .o_rdata(a_rdata)
    );

    // shared adder: subtract for the walk, add for the fold
    logic        sub_mode;
    logic [31:0] alu_a, alu_b, alu_y;
    assign alu_y = sub_mode ? (alu_a - alu_b) : (alu_a + alu_b);

    logic in_acc;
    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign in_acc  = i_valid && o_ready;

    logic h_valid;
    assign h_valid = (r_handle != '0) && ({1'b0, r_handle} <= (HANDLE_W+1)'(ENTRIES));

    logic is_set;
    assign is_set = (r_cmd == CMD_SET) || (r_cmd == CMD_MODIFY && r_handle == '0);

    logic [IDX_W-1:0] cur_link;
    assign cur_link = r_link[r_cur[ADDR_W-1:0]];

    logic t_less;
    assign t_less = d_rdata > r_t;

    always_comb begin
        n_state  = r_state;
        d_we     = 1'b0;
        d_waddr  = r_cur[ADDR_W-1:0];
        d_wdata  = alu_y;
        d_raddr  = r_cur[ADDR_W-1:0];
        a_we     = 1'b0;
        sub_mode = 1'b1;
        alu_a    = d_rdata;
        alu_b    = r_t;
        unique case (r_state)
            S_IDLE:  if (in_acc) n_state = S_DISP;
            S_DISP:  begin
                priority if (is_set) begin
                    n_state = (r_free_head != NIL) ? S_IRD : S_HRD;
                end else if (r_cmd == CMD_MODIFY || r_cmd == CMD_DELETE) begin
                    n_state = h_valid ? S_UWALK : S_HRD;
                end else begin
                    n_state = S_HRD;
                end
            end
            S_UWALK: begin
                if (r_cur == NIL || r_cnt[ADDR_W]) begin
                    if (r_cmd == CMD_DELETE) n_state = S_HRD;
                    else if (r_free_walk) n_state = S_IRD;
                end else if (r_cur == r_ent) begin
                    if (!r_free_walk && cur_link != NIL) n_state = S_URD;
                    else if (r_cmd == CMD_DELETE) n_state = S_HRD;
                    else n_state = S_IRD;
                end
            end
            S_URD: begin
                d_raddr = r_ent[ADDR_W-1:0];
                n_state = S_USUCC;
            end
            // read the successor's delta while the unlinked delta is saved
            S_USUCC: n_state = S_UFOLD;
            S_UFOLD: begin
                sub_mode = 1'b0;
                alu_b    = r_saved;
                d_we     = 1'b1;
                n_state  = (r_cmd == CMD_DELETE) ? S_HRD : S_IRD;
            end
            S_IRD: begin
                n_state = (r_cur == NIL || r_cnt[ADDR_W]) ? S_IDONE : S_ICHK;
            end
            S_ICHK: begin
                if (t_less) begin
                    d_we    = 1'b1;
                    n_state = S_IDONE;
                end else begin
                    alu_a   = r_t;
                    alu_b   = d_rdata;
                    n_state = S_IRD;
                end
            end
            S_IDONE: begin
                d_we    = 1'b1;
                d_waddr = r_ent[ADDR_W-1:0];
                d_wdata = r_t;
                a_we    = 1'b1;
                n_state = S_HRD;
            end
            S_HRD: begin
                d_raddr = r_active_head[ADDR_W-1:0];
                n_state = S_OUT;
            end
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active_head <= NIL;
            r_free_head   <= '0;
            r_time_base   <= '0;
            r_ovalid      <= 1'b0;
            r_status      <= 1'b0;
            r_hout        <= '0;
            r_oh          <= '0;
            r_od          <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_link[i] <= IDX_W'(i + 1);
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_time_base <= i_cfg_wdata;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_cmd    <= i_command;
                    r_handle <= i_handle;
                    r_arg    <= i_timer_argument;
                    r_t      <= (i_now_ms - r_time_base) + i_delay_ms;
                    r_status <= 1'b0;
                    r_hout   <= '0;
                end
                S_DISP: begin
                    r_prev      <= NIL;
                    r_cnt       <= '0;
                    r_free_walk <= 1'b0;
                    r_cur       <= r_active_head;
                    priority if (is_set) begin
                        if (r_free_head != NIL) begin
                            r_ent       <= r_free_head;
                            r_free_head <= r_link[r_free_head[ADDR_W-1:0]];
                            r_hout      <= HANDLE_W'(r_free_head) + HANDLE_W'(1);
                        end else begin
                            r_status <= 1'b1;
                        end
                    end else if (r_cmd == CMD_MODIFY) begin
                        if (h_valid) begin
                            r_ent  <= IDX_W'(r_handle - HANDLE_W'(1));
                            r_hout <= r_handle;
                        end else begin
                            r_status <= 1'b1;
                        end
                    end else if (r_cmd == CMD_DELETE) begin
                        if (h_valid) r_ent <= IDX_W'(r_handle - HANDLE_W'(1));
                    end else begin
                        r_hout <= r_handle;
                    end
                end
                S_UWALK: begin
                    // one link step per cycle over the list being searched
                    if (r_cur == NIL || r_cnt[ADDR_W]) begin
                        // not on this list: try the free list on modify
                        r_prev <= NIL;
                        r_cnt  <= '0;
                        if (r_cmd != CMD_DELETE && !r_free_walk) begin
                            r_free_walk <= 1'b1;
                            r_cur       <= r_free_head;
                        end else begin
                            r_cur <= r_active_head;
                        end
                    end else if (r_cur == r_ent) begin
                        if (r_prev != NIL) r_link[r_prev[ADDR_W-1:0]] <= cur_link;
                        else if (r_free_walk) r_free_head <= cur_link;
                        else r_active_head <= cur_link;
                        if (r_cmd == CMD_DELETE) begin
                            r_link[r_ent[ADDR_W-1:0]] <= r_free_head;
                            r_free_head <= r_ent;
                        end
                        r_prev <= NIL;
                        r_cnt  <= '0;
                        // hold the successor for the fold, else restart at the head
                        if (!r_free_walk && (cur_link != NIL || r_prev == NIL))
                            r_cur <= cur_link;
                        else
                            r_cur <= r_active_head;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= cur_link;
                        r_cnt  <= r_cnt + (ADDR_W+1)'(1);
                    end
                end
                S_URD: ;
                S_USUCC: r_saved <= d_rdata;
                S_UFOLD: r_cur <= r_active_head;
                S_IRD: ;
                S_ICHK: begin
                    if (!t_less) begin
                        r_t    <= alu_y;
                        r_prev <= r_cur;
                        r_cur  <= cur_link;
                        r_cnt  <= r_cnt + (ADDR_W+1)'(1);
                    end
                end
                S_IDONE: begin
                    r_link[r_ent[ADDR_W-1:0]] <= r_cur;
                    if (r_prev != NIL) r_link[r_prev[ADDR_W-1:0]] <= r_ent;
                    else r_active_head <= r_ent;
                end
                S_HRD: ;
                S_OUT: begin
                    if (r_active_head != NIL) begin
                        r_oh <= HANDLE_W'(r_active_head) + HANDLE_W'(1);
                        r_od <= d_rdata;
                    end else begin
                        r_oh <= '0;
                        r_od <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    logic unused_arg;
    assign unused_arg = ^a_rdata;

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_handle_out    = r_hout;
    assign o_head_handle   = r_oh;
    assign o_head_delta_ms = r_od;
endmodule
